@@ hw/rtl/bounded_list_with_search_assert.svh @@
// Assertion macros used by the bounded list RTL.
`ifndef BOUNDED_LIST_WITH_SEARCH_ASSERT_SVH
`define BOUNDED_LIST_WITH_SEARCH_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define BLC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define BLC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/blc_pkg.sv @@
// Types and codes for the bounded list with search.
package blc_pkg;

  // Request kinds
  typedef enum logic [2:0] {
    REQ_PREPEND = 3'd0,
    REQ_APPEND  = 3'd1,
    REQ_SEARCH  = 3'd2,
    REQ_READ    = 3'd3,
    REQ_CLEAR   = 3'd4
  } blc_req_e;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } blc_status_e;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } blc_state_e;

  // Field widths of the transactions
  localparam int unsigned ReqTypeW = 3;
  localparam int unsigned ValueW   = 32;
  localparam int unsigned IndexW   = 6;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned CountW   = 7;

  typedef struct packed {
    logic [ReqTypeW-1:0]      req_type;
    logic signed [ValueW-1:0] value;
    logic [IndexW-1:0]        index;
  } blc_req_t;

  typedef struct packed {
    logic [StatusW-1:0]       status;
    logic                     found;
    logic signed [ValueW-1:0] item;
    logic [CountW-1:0]        count;
  } blc_rsp_t;

  // Per-cycle commands to every cell of the chain
  typedef struct packed {
    logic shift;   // move one place towards the back, cell 0 takes the new word
    logic rotate;  // move one place towards the front, last cell takes cell 0
    logic append;  // the cell at position count takes the new word
  } blc_ctrl_t;

endpackage

@@ hw/rtl/blc_cell.sv @@
// One storage cell of the list chain.
module blc_cell #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned CNT_W      = 7,
  parameter int unsigned CELL_IDX   = 0
) (
  input  logic                    clk_i,
  input  blc_pkg::blc_ctrl_t      ctrl_i,
  input  logic [CNT_W-1:0]        count_i,
  input  logic [DATA_WIDTH-1:0]   word_i,
  input  logic [DATA_WIDTH-1:0]   left_i,
  input  logic [DATA_WIDTH-1:0]   right_i,
  output logic [DATA_WIDTH-1:0]   data_o
);

  logic [DATA_WIDTH-1:0] data_q;
  logic [DATA_WIDTH-1:0] data_d;
  logic                  data_en;

  // Next entry: from a neighbour or from the request word
  always_comb begin
    data_en = 1'b1;
    data_d  = data_q;
    if (ctrl_i.shift) begin
      data_d = left_i;
    end else if (ctrl_i.rotate) begin
      data_d = right_i;
    end else if (ctrl_i.append && (count_i == CNT_W'(CELL_IDX))) begin
      data_d = word_i;
    end else begin
      data_en = 1'b0;
    end
  end

  // Payload only, no reset
  always_ff @(posedge clk_i) begin
    if (data_en) begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

@@ hw/rtl/bounded_list_with_search.sv @@
// Bounded list with search: top level, a chain of CAPACITY cells and its controller.
// Prepend, append, clear, rejected and unknown requests: result registered on acceptance,
//   one transaction per cycle while the output is taken.
// Search and in-range read: the chain makes one full rotation past the comparator at cell 0,
//   one entry per cycle; a single request is in work.
// Reset clears count, controller and output valid asynchronously; cell contents are not reset.
`include "bounded_list_with_search_assert.svh"

module bounded_list_with_search #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  blc_pkg::blc_req_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output blc_pkg::blc_rsp_t out_data_o
);

  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam int unsigned StepW = $clog2(CAPACITY);
  localparam int unsigned IdxW  = blc_pkg::IndexW;
  localparam int unsigned WideW = (CntW > IdxW) ? CntW : IdxW;
  localparam int unsigned ValW  = blc_pkg::ValueW;

  blc_pkg::blc_state_e state_q, state_d;
  logic [CntW-1:0]       count_q, count_d;
  logic [StepW-1:0]      step_q, step_d;
  logic                  found_q, found_d;
  logic [ValW-1:0]       item_q, item_d;
  logic                  search_q;
  logic [DATA_WIDTH-1:0] word_q;
  logic [IdxW-1:0]       index_q;
  logic                  out_valid_q;
  blc_pkg::blc_rsp_t     out_q, rsp_d;
  logic                  out_load;
  logic                  out_free;
  logic                  in_acc;
  logic                  req_load;
  logic                  full;
  logic [DATA_WIDTH-1:0] word_in;
  logic [DATA_WIDTH-1:0] head;
  blc_pkg::blc_ctrl_t    ctrl;
  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];

  // Input word sign-extended to 64 bits, then fitted to the entry width
  assign word_in  = DATA_WIDTH'(64'(in_data_i.value));
  assign full     = (count_q == CntW'(CAPACITY));
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != blc_pkg::S_IDLE) || !out_free;
  assign in_acc   = in_valid_i && !in_stall_o;
  assign head     = cell_data[0];

  // Cell chain: shift towards the back on prepend, rotate towards the front on a scan
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left;
    logic [DATA_WIDTH-1:0] right;
    if (g == 0) begin : g_first
      assign left = word_in;
    end else begin : g_mid_l
      assign left = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right = cell_data[0];
    end else begin : g_mid_r
      assign right = cell_data[g+1];
    end
    blc_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CntW),
      .CELL_IDX   (g)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .count_i (count_q),
      .word_i  (word_in),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[g])
    );
  end

  // Next state, chain commands and result
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    step_d   = step_q;
    found_d  = found_q;
    item_d   = item_q;
    ctrl     = '0;
    out_load = 1'b0;
    req_load = 1'b0;
    rsp_d    = '0;
    case (state_q)
      blc_pkg::S_IDLE: begin
        if (in_acc) begin
          out_load = 1'b1;
          case (in_data_i.req_type)
            blc_pkg::REQ_PREPEND: begin
              if (full) begin
                rsp_d.status = blc_pkg::STAT_FULL;
              end else begin
                ctrl.shift = 1'b1;
                count_d    = count_q + CntW'(1);
              end
            end
            blc_pkg::REQ_APPEND: begin
              if (full) begin
                rsp_d.status = blc_pkg::STAT_FULL;
              end else begin
                ctrl.append = 1'b1;
                count_d     = count_q + CntW'(1);
              end
            end
            blc_pkg::REQ_SEARCH: begin
              out_load = 1'b0;
              req_load = 1'b1;
              found_d  = 1'b0;
              item_d   = '0;
              step_d   = '0;
              state_d  = blc_pkg::S_SCAN;
            end
            blc_pkg::REQ_READ: begin
              if (WideW'(in_data_i.index) >= WideW'(count_q)) begin
                rsp_d.status = blc_pkg::STAT_RANGE;
              end else begin
                out_load = 1'b0;
                req_load = 1'b1;
                found_d  = 1'b0;
                item_d   = '0;
                step_d   = '0;
                state_d  = blc_pkg::S_SCAN;
              end
            end
            blc_pkg::REQ_CLEAR: begin
              count_d = '0;
            end
            default: begin
              // unknown kinds change nothing
            end
          endcase
        end
      end
      blc_pkg::S_SCAN: begin
        ctrl.rotate = 1'b1;
        if (search_q && (CntW'(step_q) < count_q) && (head == word_q)) begin
          found_d = 1'b1;
        end
        if (!search_q && (WideW'(step_q) == WideW'(index_q))) begin
          item_d = ValW'(head);
        end
        if (step_q == StepW'(CAPACITY - 1)) begin
          step_d  = '0;
          state_d = blc_pkg::S_DONE;
        end else begin
          step_d = step_q + StepW'(1);
        end
      end
      blc_pkg::S_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = blc_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = blc_pkg::S_IDLE;
      end
    endcase
    if (state_q == blc_pkg::S_DONE) begin
      rsp_d.found = found_q;
      rsp_d.item  = item_q;
    end
    rsp_d.count = blc_pkg::CountW'(count_d);
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= blc_pkg::S_IDLE;
      count_q     <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      step_q  <= step_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    found_q <= found_d;
    item_q  <= item_d;
    if (req_load) begin
      search_q <= (in_data_i.req_type == blc_pkg::REQ_SEARCH);
      word_q   <= word_in;
      index_q  <= in_data_i.index;
    end
    if (out_load) begin
      out_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  `BLC_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CntW'(CAPACITY), "count above capacity")
  `BLC_ASSERT_NEXT(a_insert_grows,
    in_acc && !full && (in_data_i.req_type == blc_pkg::REQ_PREPEND ||
    in_data_i.req_type == blc_pkg::REQ_APPEND),
    count_q == $past(count_q) + CntW'(1), "accepted insert did not grow count")
  `BLC_ASSERT_NOW(a_idle_step, state_q == blc_pkg::S_IDLE, step_q == '0, "scan step not parked")
  `BLC_ASSERT_NEXT(a_scan_end, state_q == blc_pkg::S_SCAN && step_q == StepW'(CAPACITY - 1),
    state_q == blc_pkg::S_DONE, "scan did not finish after a full rotation")
  `BLC_ASSERT_NEXT(a_scan_count, state_q != blc_pkg::S_IDLE, $stable(count_q),
    "count changed during a scan")

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the bounded list with search.
module tb;

  localparam int CLK_PERIOD = 10;
  localparam int CAP        = 64;
  localparam int IDLE_PCT   = 21;
  localparam int ITEM_GOAL  = 2000;
  localparam int QUIET_FROM = 900;
  localparam int QUIET_TO   = 1200;
  localparam int HOLD_AT    = 400;
  localparam int HOLD_LEN   = 300;
  localparam int DRAIN      = CAP + 8;

  // Request kinds the block decodes as no-ops
  localparam logic [blc_pkg::ReqTypeW-1:0] REQ_SPARE_A = 3'd5;
  localparam logic [blc_pkg::ReqTypeW-1:0] REQ_SPARE_B = 3'd6;
  localparam logic [blc_pkg::ReqTypeW-1:0] REQ_SPARE_C = 3'd7;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  blc_pkg::blc_req_t in_data_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  blc_pkg::blc_rsp_t out_data_o;

  bounded_list_with_search u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Shadow copy of the list contents
  logic signed [blc_pkg::ValueW-1:0] shadow_words [CAP];
  logic [blc_pkg::IndexW-1:0]        shadow_front = '0;
  logic [blc_pkg::CountW-1:0]        shadow_count = '0;

  blc_pkg::blc_rsp_t rsp_pending [$];
  blc_pkg::blc_rsp_t want_rsp;
  int unsigned mismatches   = 0;
  int unsigned items_sent   = 0;
  int unsigned rsp_checked  = 0;
  int unsigned full_seen    = 0;
  int unsigned range_seen   = 0;
  int unsigned hits_seen    = 0;
  int unsigned spare_seen   = 0;
  logic        quiet_spell  = 1'b0;
  logic        hold_off     = 1'b0;

  typedef struct packed {
    blc_pkg::blc_req_t rq;
    logic              typed;
    blc_pkg::blc_rsp_t rsp;
  } probe_row_t;

  probe_row_t probe_rows [$];

  // Apply one request to the shadow list and return the result it gives
  function automatic blc_pkg::blc_rsp_t list_apply(input blc_pkg::blc_req_t rq);
    blc_pkg::blc_rsp_t          rs;
    int unsigned                k;
    logic [blc_pkg::IndexW-1:0] slot;
    rs = '0;
    case (rq.req_type)
      blc_pkg::REQ_PREPEND: begin
        if (shadow_count >= CAP) begin
          rs.status = blc_pkg::STAT_FULL;
        end else begin
          shadow_front               = shadow_front - 1'b1;
          shadow_words[shadow_front] = rq.value;
          shadow_count               = shadow_count + 1'b1;
        end
      end
      blc_pkg::REQ_APPEND: begin
        if (shadow_count >= CAP) begin
          rs.status = blc_pkg::STAT_FULL;
        end else begin
          slot               = shadow_front + shadow_count[blc_pkg::IndexW-1:0];
          shadow_words[slot] = rq.value;
          shadow_count       = shadow_count + 1'b1;
        end
      end
      blc_pkg::REQ_SEARCH: begin
        // front to back, stop at the first match
        for (k = 0; k < shadow_count && !rs.found; k++) begin
          slot = shadow_front + k[blc_pkg::IndexW-1:0];
          if (shadow_words[slot] == rq.value) rs.found = 1'b1;
        end
      end
      blc_pkg::REQ_READ: begin
        if (rq.index >= shadow_count) begin
          rs.status = blc_pkg::STAT_RANGE;
        end else begin
          slot    = shadow_front + rq.index;
          rs.item = shadow_words[slot];
        end
      end
      blc_pkg::REQ_CLEAR: begin
        shadow_count = '0;
        shadow_front = '0;
      end
      default: ;
    endcase
    rs.count = shadow_count;
    return rs;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
    mismatches++;
  endtask

  // Offer one transaction, wait for it to be taken, then queue its result
  task automatic send_item(input blc_pkg::blc_req_t rq, input logic typed,
                           input blc_pkg::blc_rsp_t typed_rsp);
    blc_pkg::blc_rsp_t calc;
    quiet_spell <= (items_sent >= QUIET_FROM) && (items_sent < QUIET_TO);
    while (!quiet_spell && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_data_i  <= rq;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    calc = list_apply(rq);
    if (calc.status == blc_pkg::STAT_FULL) full_seen++;
    if (calc.status == blc_pkg::STAT_RANGE) range_seen++;
    if (calc.found) hits_seen++;
    if (rq.req_type > blc_pkg::REQ_CLEAR) spare_seen++;
    rsp_pending.push_back(typed ? typed_rsp : calc);
    items_sent++;
  endtask

  task automatic add_row(input logic [blc_pkg::ReqTypeW-1:0] kind,
                         input logic [blc_pkg::ValueW-1:0] value,
                         input logic [blc_pkg::IndexW-1:0] index, input logic typed,
                         input logic [blc_pkg::StatusW-1:0] status, input logic found,
                         input logic [blc_pkg::ValueW-1:0] item,
                         input logic [blc_pkg::CountW-1:0] count);
    probe_row_t row;
    row.rq.req_type = kind;
    row.rq.value    = value;
    row.rq.index    = index;
    row.typed       = typed;
    row.rsp.status  = status;
    row.rsp.found   = found;
    row.rsp.item    = item;
    row.rsp.count   = count;
    probe_rows.push_back(row);
  endtask

  // Words biased towards extremes and a small cluster that collides often
  function automatic logic [blc_pkg::ValueW-1:0] pick_word();
    case ($urandom_range(9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'hffff_ffff;
      3:       return 32'h0;
      4, 5:    return $urandom_range(8) - 4;
      default: return $urandom;
    endcase
  endfunction

  function automatic blc_pkg::blc_req_t draw_request();
    blc_pkg::blc_req_t          rq;
    int unsigned                pick;
    logic [blc_pkg::IndexW-1:0] slot;
    rq.value = pick_word();
    rq.index = blc_pkg::IndexW'($urandom);
    pick     = $urandom_range(99);
    if (pick < 2) begin
      case ($urandom_range(2))
        0:       rq.req_type = REQ_SPARE_A;
        1:       rq.req_type = REQ_SPARE_B;
        default: rq.req_type = REQ_SPARE_C;
      endcase
    end else if (pick < 3) begin
      rq.req_type = blc_pkg::REQ_CLEAR;
    end else if (pick < 30) begin
      rq.req_type = blc_pkg::REQ_PREPEND;
    end else if (pick < 56) begin
      rq.req_type = blc_pkg::REQ_APPEND;
    end else if (pick < 79) begin
      rq.req_type = blc_pkg::REQ_SEARCH;
      // half the searches look for a word that is held
      if (shadow_count != 0 && $urandom_range(1) == 1) begin
        slot     = shadow_front + blc_pkg::IndexW'($urandom_range(shadow_count - 1));
        rq.value = shadow_words[slot];
      end
    end else begin
      rq.req_type = blc_pkg::REQ_READ;
      if (shadow_count != 0 && $urandom_range(9) < 7)
        rq.index = blc_pkg::IndexW'($urandom_range(shadow_count - 1));
    end
    return rq;
  endfunction

  // Result side: check each accepted transaction against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (rsp_pending.size() == 0) begin
        report_mismatch("unexpected result", 32'(out_data_o), 32'h0);
      end else begin
        want_rsp = rsp_pending.pop_front();
        rsp_checked++;
        if (out_data_o.status !== want_rsp.status)
          report_mismatch("status", 32'(out_data_o.status), 32'(want_rsp.status));
        if (out_data_o.found !== want_rsp.found)
          report_mismatch("found", 32'(out_data_o.found), 32'(want_rsp.found));
        if (out_data_o.item !== want_rsp.item)
          report_mismatch("item", out_data_o.item, want_rsp.item);
        if (out_data_o.count !== want_rsp.count)
          report_mismatch("count", 32'(out_data_o.count), 32'(want_rsp.count));
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk_i) begin
    out_stall_i <= hold_off || (!quiet_spell && $urandom_range(99) < IDLE_PCT);
  end

  // Long receiver hold-off so the block fills and stalls its input
  initial begin
    while (items_sent < HOLD_AT) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_LEN) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    #8_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Main sequence
  initial begin
    int unsigned       rand_items;
    int unsigned       run_len;
    blc_pkg::blc_req_t rq;
    rand_items = 0;

    // kind, value, index, typed; then status, found, item, count
    add_row(blc_pkg::REQ_READ,    32'h0,         6'd0,  1'b1,
            blc_pkg::STAT_RANGE, 1'b0, 32'h0, 7'd0);
    add_row(blc_pkg::REQ_READ,    32'h0,         6'd63, 1'b1,
            blc_pkg::STAT_RANGE, 1'b0, 32'h0, 7'd0);
    add_row(blc_pkg::REQ_SEARCH,  32'h0,         6'd0,  1'b1,
            blc_pkg::STAT_OK,    1'b0, 32'h0, 7'd0);
    add_row(blc_pkg::REQ_CLEAR,   32'hffff_ffff, 6'd63, 1'b1,
            blc_pkg::STAT_OK,    1'b0, 32'h0, 7'd0);
    add_row(blc_pkg::REQ_APPEND,  32'h7fff_ffff, 6'd0,  1'b1,
            blc_pkg::STAT_OK,    1'b0, 32'h0, 7'd1);
    add_row(blc_pkg::REQ_PREPEND, 32'h8000_0000, 6'd0,  1'b1,
            blc_pkg::STAT_OK,    1'b0, 32'h0, 7'd2);
    add_row(blc_pkg::REQ_READ,    32'h0,         6'd0,  1'b1,
            blc_pkg::STAT_OK,    1'b0, 32'h8000_0000, 7'd2);
    add_row(blc_pkg::REQ_READ,    32'h0,         6'd1,  1'b1,
            blc_pkg::STAT_OK,    1'b0, 32'h7fff_ffff, 7'd2);
    add_row(blc_pkg::REQ_READ,    32'h0,         6'd2,  1'b1,
            blc_pkg::STAT_RANGE, 1'b0, 32'h0, 7'd2);
    add_row(blc_pkg::REQ_SEARCH,  32'h7fff_ffff, 6'd0,  1'b1,
            blc_pkg::STAT_OK,    1'b1, 32'h0, 7'd2);
    add_row(blc_pkg::REQ_SEARCH,  32'h8000_0000, 6'd0,  1'b1,
            blc_pkg::STAT_OK,    1'b1, 32'h0, 7'd2);
    add_row(blc_pkg::REQ_SEARCH,  32'h0,         6'd0,  1'b1,
            blc_pkg::STAT_OK,    1'b0, 32'h0, 7'd2);
    add_row(blc_pkg::REQ_PREPEND, 32'hffff_ffff, 6'd63, 1'b0,
            blc_pkg::STAT_OK,    1'b0, 32'h0, 7'd0);
    add_row(blc_pkg::REQ_APPEND,  32'h0,         6'd63, 1'b0,
            blc_pkg::STAT_OK,    1'b0, 32'h0, 7'd0);
    add_row(blc_pkg::REQ_SEARCH,  32'h0,         6'd0,  1'b0,
            blc_pkg::STAT_OK,    1'b0, 32'h0, 7'd0);
    add_row(blc_pkg::REQ_READ,    32'h0,         6'd3,  1'b0,
            blc_pkg::STAT_OK,    1'b0, 32'h0, 7'd0);
    add_row(REQ_SPARE_A,          32'h1234_5678, 6'd1,  1'b1,
            blc_pkg::STAT_OK,    1'b0, 32'h0, 7'd4);
    add_row(REQ_SPARE_B,          32'hffff_ffff, 6'd63, 1'b1,
            blc_pkg::STAT_OK,    1'b0, 32'h0, 7'd4);
    add_row(REQ_SPARE_C,          32'h8000_0000, 6'd0,  1'b1,
            blc_pkg::STAT_OK,    1'b0, 32'h0, 7'd4);
    add_row(blc_pkg::REQ_CLEAR,   32'h0,         6'd0,  1'b1,
            blc_pkg::STAT_OK,    1'b0, 32'h0, 7'd0);
    // stale words must not be found or read once cleared
    add_row(blc_pkg::REQ_SEARCH,  32'h7fff_ffff, 6'd0,  1'b1,
            blc_pkg::STAT_OK,    1'b0, 32'h0, 7'd0);
    add_row(blc_pkg::REQ_READ,    32'h0,         6'd0,  1'b1,
            blc_pkg::STAT_RANGE, 1'b0, 32'h0, 7'd0);
    add_row(blc_pkg::REQ_PREPEND, 32'h1234_5678, 6'd0,  1'b1,
            blc_pkg::STAT_OK,    1'b0, 32'h0, 7'd1);
    add_row(blc_pkg::REQ_READ,    32'h0,         6'd0,  1'b1,
            blc_pkg::STAT_OK,    1'b0, 32'h1234_5678, 7'd1);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (probe_rows[i]) send_item(probe_rows[i].rq, probe_rows[i].typed,
                                      probe_rows[i].rsp);

    // Random part: runs of requests, most starting from an empty list
    while (rand_items < ITEM_GOAL) begin
      if ($urandom_range(9) < 8) begin
        rq          = draw_request();
        rq.req_type = blc_pkg::REQ_CLEAR;
        send_item(rq, 1'b0, '0);
        rand_items++;
      end
      run_len = $urandom_range(220, 30);
      repeat (run_len) begin
        rq = draw_request();
        send_item(rq, 1'b0, '0);
        if (rq.req_type <= blc_pkg::REQ_CLEAR) rand_items++;
      end
    end
    in_valid_i <= 1'b0;

    while (rsp_pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    $display("Run covered %0d requests and %0d checked results (%0d no-op kinds).",
             items_sent, rsp_checked, spare_seen);
    $display("Full-store drops %0d, out-of-range reads %0d, search hits %0d.",
             full_seen, range_seen, hits_seen);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ bounded_list_with_search.f @@
+incdir+hw/rtl
hw/rtl/blc_pkg.sv
hw/rtl/blc_cell.sv
hw/rtl/bounded_list_with_search.sv
dv/tb.sv
